// ----- hw/rtl/mi3_pkg.sv -----
// Package for the 3x3 matrix inverse block: item types and fixed widths.
// Used by the stream interface users and by matrix_inverse_3x3_lu.
`default_nettype none
package mi3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int QUOT_BITS     = 32;
  localparam int PROD_W        = 2 * DATA_W;      // one element product
  localparam int COF_W         = PROD_W + 1;      // signed cofactor
  localparam int DET_W         = 99;              // signed determinant
  localparam int NUM_LANES     = 9;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_r0c0;
    logic signed [DATA_W-1:0] in_r0c1;
    logic signed [DATA_W-1:0] in_r0c2;
    logic signed [DATA_W-1:0] in_r1c0;
    logic signed [DATA_W-1:0] in_r1c1;
    logic signed [DATA_W-1:0] in_r1c2;
    logic signed [DATA_W-1:0] in_r2c0;
    logic signed [DATA_W-1:0] in_r2c1;
    logic signed [DATA_W-1:0] in_r2c2;
  } mat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] inv_r0c0;
    logic signed [DATA_W-1:0] inv_r0c1;
    logic signed [DATA_W-1:0] inv_r0c2;
    logic signed [DATA_W-1:0] inv_r1c0;
    logic signed [DATA_W-1:0] inv_r1c1;
    logic signed [DATA_W-1:0] inv_r1c2;
    logic signed [DATA_W-1:0] inv_r2c0;
    logic signed [DATA_W-1:0] inv_r2c1;
    logic signed [DATA_W-1:0] inv_r2c2;
    logic                     singular;
  } inv_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mi3_stream_if.sv -----
// Valid/ready stream interface carrying one item of payload type T.
// Depends on nothing; the payload types come from mi3_pkg at the instance.
`default_nettype none
interface mi3_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/matrix_inverse_3x3_lu.sv -----
// Usage:
// mat_in carries one 3x3 matrix per item, nine signed fixed-point elements
// with FRAC_BITS fraction bits. inv_out carries the nine elements of the
// inverse in the same format, saturated to 32 bits, and a singular flag.
// When a00, the leading 2x2 minor or the determinant is zero, singular is
// set and all nine elements are zero.
// The datapath is a 40-stage pipeline: 7 stages of products, cofactors and
// determinant, 32 stages of a restoring divider that retires one quotient
// bit per stage in each of nine lanes, and a sign/saturation register.
// Items pass through the stages in order, and one item is accepted in
// every cycle while the receiver takes results.
// The whole pipeline advances together; when a result waits at the output
// and inv_out.ready is low, every stage holds and mat_in.ready drops.
// Reset (rst, synchronous) empties the pipeline; no result is pending after.
// Depends on mi3_pkg and mi3_stream_if.
`default_nettype none
module matrix_inverse_3x3_lu #(
  parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst,
  mi3_stream_if.sink   mat_in,
  mi3_stream_if.source inv_out
);
  import mi3_pkg::*;

  localparam int NUM_W  = COF_W + 2 * FRAC_BITS + 1;
  localparam int REM_W0 = (NUM_W > DET_W + QUOT_BITS) ? NUM_W : DET_W + QUOT_BITS;
  localparam int REM_W  = REM_W0 + 1;
  localparam int FRONT  = 7;
  localparam int NST    = FRONT + QUOT_BITS + 1;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [QUOT_BITS-1:0] q;
    logic                 neg;
    logic                 big;
  } lane_t;

  logic           en;
  logic [NST-1:0] v;

  assign en            = !v[NST-1] || inv_out.ready;
  assign mat_in.ready  = en;
  assign inv_out.valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], mat_in.valid};
    end
  end

  logic signed [DATA_W-1:0] a [3][3];
  always_comb begin
    a[0][0] = mat_in.data.in_r0c0;
    a[0][1] = mat_in.data.in_r0c1;
    a[0][2] = mat_in.data.in_r0c2;
    a[1][0] = mat_in.data.in_r1c0;
    a[1][1] = mat_in.data.in_r1c1;
    a[1][2] = mat_in.data.in_r1c2;
    a[2][0] = mat_in.data.in_r2c0;
    a[2][1] = mat_in.data.in_r2c1;
    a[2][2] = mat_in.data.in_r2c2;
  end

  // Stage 0: the two products of every cofactor.
  logic signed [PROD_W-1:0] p1 [3][3];
  logic signed [PROD_W-1:0] p2 [3][3];
  logic signed [DATA_W-1:0] row0_s0 [3];
  logic signed [DATA_W-1:0] row0_s1 [3];
  logic                     a00z_s0, a00z_s1, a00z_s2, a00z_s3, a00z_s4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p1[i][j] <= PROD_W'(a[(i+1)%3][(j+1)%3]) * PROD_W'(a[(i+2)%3][(j+2)%3]);
          p2[i][j] <= PROD_W'(a[(i+1)%3][(j+2)%3]) * PROD_W'(a[(i+2)%3][(j+1)%3]);
        end
        row0_s0[i] <= a[0][i];
      end
      a00z_s0 <= (a[0][0] == '0);
    end
  end

  // Stage 1: cofactors.
  logic signed [COF_W-1:0] cof_s1 [3][3];
  logic signed [COF_W-1:0] cof_s2 [3][3];
  logic signed [COF_W-1:0] cof_s3 [3][3];
  logic signed [COF_W-1:0] cof_s4 [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cof_s1[i][j] <= COF_W'(p1[i][j]) - COF_W'(p2[i][j]);
        end
        row0_s1[i] <= row0_s0[i];
      end
      a00z_s1 <= a00z_s0;
    end
  end

  // Stage 2: first-row terms of the determinant, split into two partial
  // products of at most 32 by 33 bits each.
  localparam int PP_W = DATA_W + 34;
  logic signed [PP_W-1:0] pp_lo [3];
  logic signed [PP_W-1:0] pp_hi [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pp_lo[j] <= PP_W'(row0_s1[j]) *
                    PP_W'($signed({1'b0, cof_s1[0][j][DATA_W-1:0]}));
        pp_hi[j] <= PP_W'(row0_s1[j]) *
                    PP_W'($signed(cof_s1[0][j][COF_W-1:DATA_W]));
      end
      cof_s2  <= cof_s1;
      a00z_s2 <= a00z_s1;
    end
  end

  // Stage 3: recombine partial products.
  logic signed [DET_W-1:0] term [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= (DET_W'(pp_hi[j]) <<< DATA_W) + DET_W'(pp_lo[j]);
      end
      cof_s3  <= cof_s2;
      a00z_s3 <= a00z_s2;
    end
  end

  // Stage 4: determinant.
  logic signed [DET_W-1:0] det;
  always_ff @(posedge clk) begin
    if (en) begin
      det     <= term[0] + term[1] + term[2];
      cof_s4  <= cof_s3;
      a00z_s4 <= a00z_s3;
    end
  end

  // Stage 5: magnitudes, signs and the zero-pivot test.
  logic [DET_W-1:0]     dmag;
  logic [COF_W-1:0]     nmag [NUM_LANES];
  logic [NUM_LANES-1:0] neg_s5;
  logic                 sing_s5;

  always_ff @(posedge clk) begin
    if (en) begin
      dmag    <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
      sing_s5 <= a00z_s4 || (cof_s4[2][2] == '0) || (det == '0);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          // Inverse element (i, j) is cofactor (j, i) over the determinant.
          nmag[i*3+j]   <= cof_s4[j][i][COF_W-1] ? COF_W'(-cof_s4[j][i])
                                                 : COF_W'(cof_s4[j][i]);
          neg_s5[i*3+j] <= cof_s4[j][i][COF_W-1] ^ det[DET_W-1];
        end
      end
    end
  end

  // Stage 6: rounding numerator 2|n| + |d| over divisor 2|d|, and the test
  // for a quotient of 2^32 or more.
  logic [REM_W-1:0] dvs     [QUOT_BITS];
  lane_t            ln      [QUOT_BITS+1][NUM_LANES];
  lane_t            ln_next [QUOT_BITS][NUM_LANES];
  logic             sing    [QUOT_BITS+1];
  logic [REM_W-1:0] num_w   [NUM_LANES];
  logic [REM_W-1:0] dvs_w;

  always_comb begin
    dvs_w = REM_W'(dmag) << 1;
    for (int l = 0; l < NUM_LANES; l++) begin
      num_w[l] = (REM_W'(nmag[l]) << (2 * FRAC_BITS + 1)) + REM_W'(dmag);
    end
  end

  // Divider stages: stage s settles quotient bit QUOT_BITS-1-s.
  always_comb begin
    for (int s = 0; s < QUOT_BITS; s++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        ln_next[s][l] = ln[s][l];
        if (ln[s][l].rem >= (dvs[s] << (QUOT_BITS - 1 - s))) begin
          ln_next[s][l].rem = ln[s][l].rem - (dvs[s] << (QUOT_BITS - 1 - s));
          ln_next[s][l].q[QUOT_BITS-1-s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs[0]  <= dvs_w;
      sing[0] <= sing_s5;
      for (int l = 0; l < NUM_LANES; l++) begin
        ln[0][l].rem <= num_w[l];
        ln[0][l].q   <= '0;
        ln[0][l].neg <= neg_s5[l];
        ln[0][l].big <= (num_w[l] >= (dvs_w << QUOT_BITS));
      end
      for (int s = 1; s < QUOT_BITS; s++) begin
        dvs[s] <= dvs[s-1];
      end
      for (int s = 0; s < QUOT_BITS; s++) begin
        sing[s+1] <= sing[s];
        for (int l = 0; l < NUM_LANES; l++) begin
          ln[s+1][l] <= ln_next[s][l];
        end
      end
    end
  end

  // Output register: sign, saturation and the singular case.
  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MAX_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] res      [NUM_LANES];
  logic [DATA_W-1:0] res_next [NUM_LANES];
  logic              sing_out;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_t f;
      f = ln[QUOT_BITS][l];
      if (sing[QUOT_BITS]) begin
        res_next[l] = '0;
      end else if (f.neg) begin
        res_next[l] = (f.big || f.q > MAX_NEG) ? MAX_NEG : DATA_W'(-f.q);
      end else begin
        res_next[l] = (f.big || f.q[QUOT_BITS-1]) ? MAX_POS : f.q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res      <= res_next;
      sing_out <= sing[QUOT_BITS];
    end
  end

  always_comb begin
    inv_out.data.inv_r0c0 = res[0];
    inv_out.data.inv_r0c1 = res[1];
    inv_out.data.inv_r0c2 = res[2];
    inv_out.data.inv_r1c0 = res[3];
    inv_out.data.inv_r1c1 = res[4];
    inv_out.data.inv_r1c2 = res[5];
    inv_out.data.inv_r2c0 = res[6];
    inv_out.data.inv_r2c1 = res[7];
    inv_out.data.inv_r2c2 = res[8];
    inv_out.data.singular = sing_out;
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_matrix_inverse_3x3_lu.sv -----
// Testbench for matrix_inverse_3x3_lu: drives matrices with random gaps and
// stalls and checks every inverse against known values for the directed cases or an exact cofactor/determinant model.
// Depends on mi3_pkg, mi3_stream_if and the block itself.
`timescale 1ns / 100ps
module tb_matrix_inverse_3x3_lu;
  import mi3_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 40;
  localparam int NUM_DIRECTED = 14;
  localparam int NUM_RANDOM = 1300;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;
  localparam logic signed [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mi3_stream_if #(.T(mat_t)) mat_in ();
  mi3_stream_if #(.T(inv_t)) inv_out ();

  matrix_inverse_3x3_lu DUT (
    .clk(clk), .rst(rst), .mat_in(mat_in.sink), .inv_out(inv_out.source)
  );

  inv_t expected_inverses[$];
  int mismatches = 0;
  bit stim_done = 0;
  bit quiet = 0;
  bit long_hold = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // Exact inverse: round(2^(2F) * adj / det), halves away from zero, saturated.
  function automatic logic signed [31:0] div_round_sat(logic signed [255:0] num,
                                                       logic signed [255:0] den);
    logic [255:0] n, d, q;
    logic neg;
    begin
      neg = num[255] ^ den[255];
      n = num[255] ? -num : num;
      d = den[255] ? -den : den;
      q = (2 * n + d) / (2 * d);
      if (neg) begin
        if (q > 256'h8000_0000) return MINV;
        return -q[31:0];
      end
      if (q > 256'h7FFF_FFFF) return MAXV;
      return q[31:0];
    end
  endfunction

  function automatic inv_t invert_matrix(mat_t m);
    logic signed [255:0] a[3][3];
    logic signed [255:0] cof[3][3];
    logic signed [255:0] det;
    logic signed [31:0] res[9];
    inv_t r;
    begin
      a[0][0] = m.in_r0c0; a[0][1] = m.in_r0c1; a[0][2] = m.in_r0c2;
      a[1][0] = m.in_r1c0; a[1][1] = m.in_r1c1; a[1][2] = m.in_r1c2;
      a[2][0] = m.in_r2c0; a[2][1] = m.in_r2c1; a[2][2] = m.in_r2c2;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                    - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
      det = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
      r = '0;
      if (a[0][0] == 0 || cof[2][2] == 0 || det == 0) begin
        r.singular = 1'b1;
        return r;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          res[i*3+j] = div_round_sat(cof[j][i] <<< (2 * FRAC), det);
      r = {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
           1'b0};
      return r;
    end
  endfunction

  function automatic logic [31:0] rand_element();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? MAXV : MINV;
      2: return $urandom_range(0, 3) - 1;
      3: return 0;
      default: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    begin
      m = {rand_element(), rand_element(), rand_element(), rand_element(),
           rand_element(), rand_element(), rand_element(), rand_element(),
           rand_element()};
      // Mostly well-conditioned: nudge the diagonal up so elimination passes.
      if ($urandom_range(0, 3) != 0) begin
        m.in_r0c0 = m.in_r0c0 | 32'h0001_0000;
        m.in_r1c1 = m.in_r1c1 + 3 * ONE;
        m.in_r2c2 = m.in_r2c2 + 5 * ONE;
      end
      return m;
    end
  endfunction

  mat_t directed_mats[NUM_DIRECTED];
  inv_t directed_known[NUM_DIRECTED];
  bit directed_has_known[NUM_DIRECTED];

  task automatic send_matrix(mat_t m, inv_t exp_val, bit use_exp);
    int gap;
    begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 15);
        mat_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      mat_in.valid <= 1'b1;
      mat_in.data <= m;
      @(posedge clk);
      while (!mat_in.ready) @(posedge clk);
      if (use_exp) expected_inverses.push_back(exp_val);
      else expected_inverses.push_back(invert_matrix(m));
      @(negedge clk);
    end
  endtask

  initial begin
    inv_t z;
    z = '0;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      directed_mats[i] = '0;
      directed_known[i] = '0;
      directed_has_known[i] = 0;
    end
    directed_mats[0] = '0;
    directed_known[0] = z; directed_known[0].singular = 1'b1; directed_has_known[0] = 1;
    directed_mats[1].in_r0c0 = ONE; directed_mats[1].in_r1c1 = ONE;
    directed_mats[1].in_r2c2 = ONE;
    directed_known[1].inv_r0c0 = ONE; directed_known[1].inv_r1c1 = ONE;
    directed_known[1].inv_r2c2 = ONE; directed_has_known[1] = 1;
    // Invertible, but a zero leading element means a row exchange is needed.
    directed_mats[2].in_r0c1 = ONE; directed_mats[2].in_r1c0 = ONE;
    directed_mats[2].in_r2c2 = ONE;
    directed_known[2] = z; directed_known[2].singular = 1'b1; directed_has_known[2] = 1;
    // Leading 2x2 minor is zero.
    directed_mats[3] = {ONE, ONE, 32'd0, ONE, ONE, 32'd0, 32'd0, 32'd0, ONE};
    directed_known[3] = z; directed_known[3].singular = 1'b1; directed_has_known[3] = 1;
    // Determinant is zero with nonzero earlier pivots.
    directed_mats[4] = {ONE, 32'd0, ONE, 32'd0, ONE, ONE, ONE, ONE, 2 * ONE};
    directed_known[4] = z; directed_known[4].singular = 1'b1; directed_has_known[4] = 1;
    // Tiny diagonal: the inverse saturates high.
    directed_mats[5].in_r0c0 = 1; directed_mats[5].in_r1c1 = 1;
    directed_mats[5].in_r2c2 = 1;
    directed_known[5].inv_r0c0 = MAXV; directed_known[5].inv_r1c1 = MAXV;
    directed_known[5].inv_r2c2 = MAXV; directed_has_known[5] = 1;
    directed_mats[6].in_r0c0 = -1; directed_mats[6].in_r1c1 = -1;
    directed_mats[6].in_r2c2 = -1;
    directed_known[6].inv_r0c0 = MINV; directed_known[6].inv_r1c1 = MINV;
    directed_known[6].inv_r2c2 = MINV; directed_has_known[6] = 1;
    directed_mats[7] = {MAXV, MAXV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV};
    directed_mats[8] = {MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV};
    directed_mats[9] = {MINV, 32'd0, 32'd0, 32'd0, MINV, 32'd0, 32'd0, 32'd0, MAXV};
    directed_mats[10] = {2 * ONE, ONE, 32'd0, ONE, 2 * ONE, ONE, 32'd0, ONE, 2 * ONE};
    directed_mats[11] = {3 * ONE, 32'd0, 32'd0, 32'd0, 3 * ONE, 32'd0,
                         32'd0, 32'd0, 3 * ONE};
    directed_mats[12] = {-ONE, 32'sd5, -32'sd7, 32'hFFFF, 4 * ONE, -32'sd3,
                         32'sd11, 32'sd13, -2 * ONE};
    directed_mats[13] = {32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678,
                         32'hFFFF_0000, 32'h0000_FFFF, 32'h8765_4321, 32'h0F0F_0F0F,
                         32'hF0F0_F0F0};

    mat_in.valid = 1'b0;
    mat_in.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_matrix(directed_mats[i], directed_known[i], directed_has_known[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) long_hold = 1;
      if (i == 600) begin
        // Hold off until the pipeline has drained.
        mat_in.valid <= 1'b0;
        while (expected_inverses.size() != 0) @(negedge clk);
      end
      if (i == NUM_RANDOM - 150) quiet = 1;
      send_matrix(random_matrix(), '0, 0);
    end
    mat_in.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver stalls, plus one long hold-off so the pipeline fills and backs up.
  initial begin
    int n;
    inv_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        inv_out.ready <= 1'b0;
        repeat (120) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        inv_out.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        inv_out.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    inv_t exp_val;
    if (!rst && inv_out.valid && inv_out.ready) begin
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", inv_out.data);
      end else begin
        exp_val = expected_inverses.pop_front();
        if (inv_out.data !== exp_val) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", exp_val, inv_out.data);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
